// File: src/mpfe_pkg.sv
// ----------------------------------------------------------------------------
// mpfe_pkg
// Shared types, constants and the 5x7 font table for the page framebuffer.
// ----------------------------------------------------------------------------
package mpfe_pkg;

   localparam int ScreenWidth = 128;
   localparam int ScreenPages = 8;
   localparam int ScreenRows  = ScreenPages * 8;
   localparam int StoreSize   = ScreenWidth * ScreenPages;
   localparam int AddrW       = $clog2(StoreSize);
   localparam int ColW        = $clog2(ScreenWidth);
   localparam int PageW       = (ScreenPages > 1) ? $clog2(ScreenPages) : 1;

   localparam logic [2:0] REQ_SET   = 3'd0;
   localparam logic [2:0] REQ_COLOR = 3'd1;
   localparam logic [2:0] REQ_GLYPH = 3'd2;
   localparam logic [2:0] REQ_CLEAR = 3'd3;
   localparam logic [2:0] REQ_READ  = 3'd4;

   localparam logic [7:0] LUMA_RESET = 8'd128;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  x_pos;
      logic [6:0]  y_pos;
      logic        pixel_on;
      logic [15:0] pixel_color;
      logic [7:0]  char_code;
      logic        invert_glyph;
      logic [2:0]  read_page;
      logic [6:0]  read_column;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] done_type;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      logic [2:0]  kind;      // original request kind
      logic        do_write;  // pixel or glyph work
      logic        do_clear;
      logic        do_read;
      logic        is_glyph;
      logic [8:0]  x;         // column (pixel) or glyph left column
      logic [7:0]  y;
      logic        lit;
      logic [34:0] glyph;     // 5 columns x 7 rows, already inverted
   } cmd_type;

   function automatic logic [39:0] font_row(input logic [6:0] idx);
      logic [39:0] f;
      unique case (idx)
         7'd0: f = 40'h0000000000; 7'd1: f = 40'h00005F0000; 7'd2: f = 40'h0007000700;
         7'd3: f = 40'h147F147F14; 7'd4: f = 40'h242A7F2A12; 7'd5: f = 40'h2313086462;
         7'd6: f = 40'h3649552250; 7'd7: f = 40'h0005030000; 7'd8: f = 40'h001C224100;
         7'd9: f = 40'h0041221C00; 7'd10: f = 40'h082A1C2A08; 7'd11: f = 40'h08083E0808;
         7'd12: f = 40'h0050300000; 7'd13: f = 40'h0808080808; 7'd14: f = 40'h0060600000;
         7'd15: f = 40'h2010080402; 7'd16: f = 40'h3E5149453E; 7'd17: f = 40'h00427F4000;
         7'd18: f = 40'h4261514946; 7'd19: f = 40'h2141454B31; 7'd20: f = 40'h1814127F10;
         7'd21: f = 40'h2745454539; 7'd22: f = 40'h3C4A494930; 7'd23: f = 40'h0171090503;
         7'd24: f = 40'h3649494936; 7'd25: f = 40'h064949291E; 7'd26: f = 40'h0036360000;
         7'd27: f = 40'h0056360000; 7'd28: f = 40'h0008142241; 7'd29: f = 40'h1414141414;
         7'd30: f = 40'h4122140800; 7'd31: f = 40'h0201510906; 7'd32: f = 40'h324979413E;
         7'd33: f = 40'h7E1111117E; 7'd34: f = 40'h7F49494936; 7'd35: f = 40'h3E41414122;
         7'd36: f = 40'h7F4141221C; 7'd37: f = 40'h7F49494941; 7'd38: f = 40'h7F09090101;
         7'd39: f = 40'h3E41415132; 7'd40: f = 40'h7F0808087F; 7'd41: f = 40'h00417F4100;
         7'd42: f = 40'h2040413F01; 7'd43: f = 40'h7F08142241; 7'd44: f = 40'h7F40404040;
         7'd45: f = 40'h7F0204027F; 7'd46: f = 40'h7F0408107F; 7'd47: f = 40'h3E4141413E;
         7'd48: f = 40'h7F09090906; 7'd49: f = 40'h3E4151215E; 7'd50: f = 40'h7F09192946;
         7'd51: f = 40'h4649494931; 7'd52: f = 40'h01017F0101; 7'd53: f = 40'h3F4040403F;
         7'd54: f = 40'h1F2040201F; 7'd55: f = 40'h7F2018207F; 7'd56: f = 40'h6314081463;
         7'd57: f = 40'h0304780403; 7'd58: f = 40'h6151494543; 7'd59: f = 40'h00007F4141;
         7'd60: f = 40'h0204081020; 7'd61: f = 40'h41417F0000; 7'd62: f = 40'h0402010204;
         7'd63: f = 40'h4040404040; 7'd64: f = 40'h0001020400; 7'd65: f = 40'h2054545478;
         7'd66: f = 40'h7F48444438; 7'd67: f = 40'h3844444420; 7'd68: f = 40'h384444487F;
         7'd69: f = 40'h3854545418; 7'd70: f = 40'h087E090102; 7'd71: f = 40'h081454543C;
         7'd72: f = 40'h7F08040478; 7'd73: f = 40'h00447D4000; 7'd74: f = 40'h2040443D00;
         7'd75: f = 40'h007F102844; 7'd76: f = 40'h00417F4000; 7'd77: f = 40'h7C04180478;
         7'd78: f = 40'h7C08040478; 7'd79: f = 40'h3844444438; 7'd80: f = 40'h7C14141408;
         7'd81: f = 40'h081414187C; 7'd82: f = 40'h7C08040408; 7'd83: f = 40'h4854545420;
         7'd84: f = 40'h043F444020; 7'd85: f = 40'h3C4040207C; 7'd86: f = 40'h1C2040201C;
         7'd87: f = 40'h3C4030403C; 7'd88: f = 40'h4428102844; 7'd89: f = 40'h0C5050503C;
         7'd90: f = 40'h4464544C44; 7'd91: f = 40'h0008364100; 7'd92: f = 40'h00007F0000;
         7'd93: f = 40'h0041360800; 7'd94: f = 40'h08082A1C08;
         default: f = 40'h0201510906;
      endcase
      return f;
   endfunction

endpackage

// File: src/mpfe_front.sv
// ----------------------------------------------------------------------------
// mpfe_front
// Accepts requests, computes luma, looks up glyphs, queues classified commands.
// ----------------------------------------------------------------------------
module mpfe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          luma_threshold,
   input  logic                req_valid,
   output logic                req_stall,
   input  mpfe_pkg::req_type   req_payload,
   output logic                cmd_valid,
   input  logic                cmd_take,
   output mpfe_pkg::cmd_type   cmd_data
);
   import mpfe_pkg::*;

   localparam int QDepth = 4;
   localparam int QW     = $clog2(QDepth);

   // stage 1: register the request and luma products
   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_req_ff;
   logic [15:0] s1_pr_ff, s1_pg_ff, s1_pb_ff;
   logic        s1_go;

   cmd_type     q_ff [QDepth];
   logic [QW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QW:0]   count_ff, count_in;
   logic          q_push, q_pop;

   // keep one slot for the beat in stage 1
   assign req_stall   = (count_ff + (QW+1)'(s1_valid_ff)) >= (QW+1)'(QDepth);
   assign s1_go       = req_valid && !req_stall;
   assign s1_valid_in = s1_go;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
      if (s1_go) begin
         s1_req_ff <= req_payload;
         s1_pr_ff  <= 16'({req_payload.pixel_color[15:11], 3'b000}) * 16'd77;
         s1_pg_ff  <= 16'({req_payload.pixel_color[10:5], 2'b00}) * 16'd150;
         s1_pb_ff  <= 16'({req_payload.pixel_color[4:0], 3'b000}) * 16'd29;
      end
   end

   // stage 2: classify
   cmd_type     cmd_new;
   logic [17:0] luma_sum;
   logic [7:0]  code;
   logic [39:0] font;
   logic [34:0] gbits;

   always_comb begin
      luma_sum = 18'(s1_pr_ff) + 18'(s1_pg_ff) + 18'(s1_pb_ff);
      code = s1_req_ff.char_code;
      if (code < 8'h20 || code > 8'h7E) code = 8'h3F;
      font = font_row(7'(code - 8'h20));
      for (int c = 0; c < 5; c++) begin
         gbits[c*7 +: 7] = font[(4-c)*8 +: 7] ^ {7{s1_req_ff.invert_glyph}};
      end
      cmd_new          = '0;
      cmd_new.kind     = s1_req_ff.req_type;
      cmd_new.x        = {1'b0, s1_req_ff.x_pos};
      cmd_new.y        = {1'b0, s1_req_ff.y_pos};
      cmd_new.glyph    = gbits;
      unique case (s1_req_ff.req_type)
         REQ_SET: begin
            cmd_new.do_write = 1'b1;
            cmd_new.lit      = s1_req_ff.pixel_on;
         end
         REQ_COLOR: begin
            cmd_new.do_write = 1'b1;
            cmd_new.lit      = luma_sum[15:8] >= luma_threshold;
         end
         REQ_GLYPH: begin
            cmd_new.is_glyph = 1'b1;
            cmd_new.do_write = (9'(s1_req_ff.x_pos) + 9'd5) <= 9'(ScreenWidth);
         end
         REQ_CLEAR: cmd_new.do_clear = 1'b1;
         REQ_READ: begin
            // byte read: y carries the page, x the column
            cmd_new.do_read = 1'b1;
            cmd_new.x       = {2'b00, s1_req_ff.read_column};
            cmd_new.y       = {5'b00000, s1_req_ff.read_page};
         end
         default: ;
      endcase
   end

   assign q_push   = s1_valid_ff;
   assign q_pop    = cmd_take;
   assign count_in = count_ff + (QW+1)'(q_push) - (QW+1)'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (q_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
      if (q_push) q_ff[wr_ptr_ff] <= cmd_new;
   end

   assign cmd_valid = count_ff != '0;
   assign cmd_data  = q_ff[rd_ptr_ff];

endmodule

// File: src/mpfe_back.sv
// ----------------------------------------------------------------------------
// mpfe_back
// Executes commands on the frame store: pixel and glyph read-modify-write,
// clearing sweep, byte read, and the result register.
// ----------------------------------------------------------------------------
module mpfe_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_take,
   input  mpfe_pkg::cmd_type  cmd_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mpfe_pkg::rsp_type  rsp_payload
);
   import mpfe_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_RD    = 6'b000010,  // memory read issued
      ST_WR    = 6'b000100,  // modify and write back
      ST_CLEAR = 6'b001000,
      ST_INIT  = 6'b010000,  // clearing pass after reset
      ST_DONE  = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff;
   logic [2:0]  gcol_ff, gcol_in;    // glyph column 0..4
   logic        gpage_ff, gpage_in;  // 0: first page touched, 1: second
   logic [AddrW:0] sweep_ff, sweep_in;

   logic [7:0]  mem [StoreSize];
   logic [7:0]  rdata_ff;
   logic        mem_re, mem_we;
   logic [AddrW-1:0] mem_ra, mem_wa;
   logic [7:0]  mem_wd;

   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   // address of the byte being touched
   logic [8:0]  col;
   logic [4:0]  page;
   logic        col_ok, page_ok;
   logic [AddrW-1:0] cur_addr;
   logic [15:0] pmask, pbits;  // 16-row window starting at page of y
   logic [7:0]  bmask, bbits;

   always_comb begin
      col      = cmd_ff.is_glyph ? cmd_ff.x + 9'(gcol_ff) : cmd_ff.x;
      page     = 5'(cmd_ff.y[7:3]) + 5'(gpage_ff);
      col_ok   = col < 9'(ScreenWidth);
      page_ok  = page < 5'(ScreenPages);
      cur_addr = AddrW'(32'(page) * ScreenWidth + 32'(col));
      if (cmd_ff.is_glyph) begin
         pmask = 16'h7F << cmd_ff.y[2:0];
         pbits = 16'(cmd_ff.glyph[gcol_ff*7 +: 7]) << cmd_ff.y[2:0];
      end else begin
         pmask = 16'h1 << cmd_ff.y[2:0];
         pbits = {16{cmd_ff.lit}} & pmask;
      end
      bmask = gpage_ff ? pmask[15:8] : pmask[7:0];
      bbits = gpage_ff ? pbits[15:8] : pbits[7:0];
   end

   logic touch_ok;
   assign touch_ok = col_ok && page_ok && (bmask != 8'h00);

   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      gcol_in  = gcol_ff;
      gpage_in = gpage_ff;
      sweep_in = sweep_ff;
      mem_re   = 1'b0;
      mem_ra   = cur_addr;
      mem_we   = 1'b0;
      mem_wa   = cur_addr;
      mem_wd   = (rdata_ff & ~bmask) | bbits;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_wa   = sweep_ff[AddrW-1:0];
            mem_wd   = 8'h00;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (AddrW+1)'(StoreSize - 1))
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
         end
         ST_IDLE: begin
            gcol_in  = '0;
            gpage_in = 1'b0;
            sweep_in = '0;
            if (cmd_take) begin
               if (cmd_data.do_clear)      state_in = ST_CLEAR;
               else if (cmd_data.do_write) state_in = ST_RD;
               else if (cmd_data.do_read)  state_in = ST_RD;
               else                        state_in = ST_DONE;
            end
         end
         ST_RD: begin
            if (cmd_ff.do_read) begin
               mem_re = 1'b1;
               mem_ra = AddrW'(32'(cmd_ff.y[2:0]) * ScreenWidth + 32'(cmd_ff.x[6:0]));
               state_in = ST_DONE;
            end else begin
               mem_re   = touch_ok;
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            mem_we = touch_ok;
            if (!cmd_ff.is_glyph) state_in = ST_DONE;
            else if (!gpage_ff) begin
               gpage_in = 1'b1;
               state_in = ST_RD;
            end else begin
               gpage_in = 1'b0;
               gcol_in  = gcol_ff + 3'd1;
               state_in = (gcol_ff == 3'd4) ? ST_DONE : ST_RD;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // read flags for the byte read: y holds page, x holds column
   logic rd_ok;
   assign rd_ok = (32'(cmd_ff.y[2:0]) < ScreenPages) && (32'(cmd_ff.x[6:0]) < ScreenWidth);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         gcol_ff      <= '0;
         gpage_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         gcol_ff  <= gcol_in;
         gpage_ff <= gpage_in;
         if (state_ff == ST_DONE)             rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (cmd_take) cmd_ff <= cmd_data;
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rdata_ff <= mem[mem_ra];
      if (state_ff == ST_DONE) begin
         rsp_ff.done_type <= cmd_ff.kind;
         rsp_ff.read_data <= (cmd_ff.do_read && rd_ok) ? rdata_ff : 8'h00;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: src/mono_page_framebuffer_engine_top.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_engine_top
// 128x64 page framebuffer with pixel, color, glyph, clear and read requests.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_stall/req_payload; each beat yields one
// result beat on rsp_valid/rsp_stall/rsp_payload, in order. The front end
// registers the request, computes luma and fetches the glyph, then queues a
// command (4 deep) for the back end. The back end owns the single-port frame
// store, one access per cycle, and takes a new command only once the previous
// result beat has left. A pixel goes through take, read, write, done and
// result; a glyph reads and writes two bytes per column; a clear sweeps the
// whole store; a read issues one memory read; a skipped glyph or unknown kind
// touches no memory.
// After reset the back end sweeps the whole store to zero; requests
// queue meanwhile. luma_threshold sits at CSR address 0, reset 128.
// A stalled result holds; the back end waits and the queue then fills and
// raises req_stall.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_engine_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mpfe_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mpfe_pkg::rsp_type  rsp_payload,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [0:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import mpfe_pkg::*;

   logic [7:0] luma_ff;
   logic       cmd_valid, cmd_take;
   cmd_type    cmd_data;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) luma_ff <= LUMA_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 1'b0)
         luma_ff <= csr_pwdata[7:0];
   end
   assign csr_prdata = (csr_paddr == 1'b0) ? {24'h0, luma_ff} : 32'h0;

   mpfe_front u_front (
      .clock, .reset, .luma_threshold(luma_ff),
      .req_valid, .req_stall, .req_payload,
      .cmd_valid, .cmd_take, .cmd_data
   );

   mpfe_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_payload
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat dropped under stall");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid)
      else $error("command taken from empty queue");
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.done_type != REQ_READ |-> rsp_payload.read_data == 8'h00)
      else $error("nonzero data on non-read result");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the page framebuffer: drives pixel, color, glyph, clear and
// read requests and checks every result against a local frame store model.
// ----------------------------------------------------------------------------
module tb;
   import mpfe_pkg::*;

   localparam int ReqW = $bits(req_type);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [0:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   mono_page_framebuffer_engine_top dut (.*);

   initial forever #4 clock = ~clock;

   // model state
   logic [7:0] pix_store [StoreSize];
   logic [7:0] thresh;
   rsp_type done_q[$];
   int errors = 0;
   int send_idle = 0, recv_idle = 0;
   int hold_cycles = 0;

   // font table, 95 glyphs x 5 columns, column 0 in the top byte
   logic [39:0] font [95];
   initial begin
      font = '{
         40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
         40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
         40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
         40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
         40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
         40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
         40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
         40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
         40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
         40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
         40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
         40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
         40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040, 40'h0001020400,
         40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
         40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
         40'h007F102844, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
         40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
         40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
         40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08};
   end

   task automatic plot(input int col, input int row, input logic lit);
      int a;
      if (col >= ScreenWidth || row >= ScreenRows) return;
      a = (row >> 3) * ScreenWidth + col;
      pix_store[a][row & 7] = lit;
   endtask

   function automatic logic [7:0] luma_of(input logic [15:0] px);
      int r, g, b;
      r = px[15:11] << 3;
      g = px[10:5] << 2;
      b = px[4:0] << 3;
      return 8'((r * 77 + g * 150 + b * 29) >> 8);
   endfunction

   task automatic apply_request(input req_type rq);
      rsp_type rs;
      int code;
      logic [7:0] bits;
      rs.read_data = 8'h00;
      rs.done_type = rq.req_type;
      unique case (rq.req_type)
         REQ_SET: plot(rq.x_pos, rq.y_pos, rq.pixel_on);
         REQ_COLOR: plot(rq.x_pos, rq.y_pos, luma_of(rq.pixel_color) >= thresh);
         REQ_GLYPH: begin
            if (int'(rq.x_pos) + 5 <= ScreenWidth) begin
               code = rq.char_code;
               if (code < 8'h20 || code > 8'h7E) code = 8'h3F;
               for (int c = 0; c < 5; c++) begin
                  bits = font[code - 8'h20][39 - 8*c -: 8];
                  if (rq.invert_glyph) bits = ~bits;
                  for (int r = 0; r < 7; r++) plot(rq.x_pos + c, rq.y_pos + r, bits[r]);
               end
            end
         end
         REQ_CLEAR: foreach (pix_store[i]) pix_store[i] = 8'h00;
         REQ_READ: rs.read_data = pix_store[rq.read_page * ScreenWidth + rq.read_column];
         default: ;
      endcase
      done_q.push_back(rs);
   endtask

   // one request beat; the prediction is made at acceptance
   // valid stays high after the beat until the sender idles or drains
   task automatic send_req(input req_type rq);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_request(rq);
      @(negedge clock);
   endtask

   // receiver stall and result check
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
      end
   end

   always @(posedge clock) begin
      rsp_type ex;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (done_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_payload);
            errors++;
         end else begin
            ex = done_q.pop_front();
            if (ex.read_data !== rsp_payload.read_data)
               begin
                  $display("%0t: read_data exp %h got %h", $time, ex.read_data,
                           rsp_payload.read_data);
                  errors++;
               end
            if (ex.done_type !== rsp_payload.done_type) begin
               $display("%0t: done_type exp %h got %h", $time, ex.done_type,
                        rsp_payload.done_type);
               errors++;
            end
         end
      end
   end

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (done_q.size() != 0) @(negedge clock);
      repeat (1100) @(negedge clock);
   endtask

   task automatic write_thresh(input logic [7:0] v);
      wait_drain();
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= '0; csr_pwdata <= 32'(v);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      thresh = v;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   function automatic req_type rand_req(input int kind);
      req_type rq;
      rq = ReqW'({$urandom, $urandom});
      rq.req_type = 3'(kind);
      // mostly on screen, sometimes anywhere
      if ($urandom_range(9) != 0) begin
         rq.x_pos = 8'($urandom_range(ScreenWidth - 1));
         rq.y_pos = 7'($urandom_range(ScreenRows - 1));
      end
      return rq;
   endfunction

   function automatic req_type mk(input logic [2:0] k, input int x, input int y,
                                  input int extra, input logic inv);
      req_type rq;
      rq = '0;
      rq.req_type = k; rq.x_pos = 8'(x); rq.y_pos = 7'(y);
      rq.pixel_on = extra[0]; rq.pixel_color = 16'(extra); rq.char_code = 8'(extra);
      rq.invert_glyph = inv;
      rq.read_page = 3'(y >> 3); rq.read_column = 7'(x);
      return rq;
   endfunction

   task automatic test_directed();
      send_req(mk(REQ_SET, 0, 0, 1, 0));
      send_req(mk(REQ_SET, 127, 63, 1, 0));
      send_req(mk(REQ_SET, 200, 100, 1, 0));
      send_req(mk(REQ_SET, 127, 63, 0, 0));
      send_req(mk(REQ_COLOR, 5, 9, 16'hFFFF, 0));
      send_req(mk(REQ_COLOR, 6, 9, 16'h0000, 0));
      send_req(mk(REQ_GLYPH, 10, 3, 8'h41, 0));
      send_req(mk(REQ_GLYPH, 20, 60, 8'h05, 1));
      send_req(mk(REQ_GLYPH, 124, 0, 8'h41, 0));
      send_req(mk(REQ_GLYPH, 123, 0, 8'hFF, 1));
      send_req(mk(REQ_GLYPH, 0, 127, 8'h7E, 0));
      for (int c = 0; c < 6; c++) send_req(mk(REQ_READ, 10 + c, 3, 0, 0));
      send_req(mk(REQ_READ, 127, 63, 0, 0));
      send_req(mk(REQ_READ, 123, 0, 0, 0));
      send_req(mk(3'd5, 1, 1, 0, 0));
      send_req(mk(3'd7, 255, 127, 16'hFFFF, 1));
      send_req(mk(REQ_CLEAR, 0, 0, 0, 0));
      send_req(mk(REQ_READ, 10, 3, 0, 0));
      send_req(mk(REQ_READ, 0, 0, 0, 0));
   endtask

   task automatic test_random(input int n);
      int k, p;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(99);
         if (p < 30) k = REQ_SET;
         else if (p < 55) k = REQ_COLOR;
         else if (p < 70) k = REQ_GLYPH;
         else if (p < 71) k = REQ_CLEAR;
         else if (p < 97) k = REQ_READ;
         else k = $urandom_range(7, 5);
         send_req(rand_req(k));
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      req_valid <= 1'b0;
      @(negedge clock);
      test_random(20);
      wait_drain();
      test_random(10);
   endtask

   initial begin
      foreach (pix_store[i]) pix_store[i] = 8'h00;
      thresh = LUMA_RESET;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      write_thresh(8'd0);
      send_idle = 33; recv_idle = 73;
      test_random(400);
      write_thresh(8'd255);
      send_idle = 73; recv_idle = 33;
      test_random(400);
      write_thresh(8'($urandom_range(255)));
      send_idle = 0; recv_idle = 0;
      test_random(480);
      test_backpressure();
      wait_drain();
      if (errors == 0)
         $display("** mono_page_framebuffer_engine_top: PASSED **");
      else
         $display("** mono_page_framebuffer_engine_top: FAILED **");
      $finish;
   end

   initial begin
      #40ms;
      $display("** mono_page_framebuffer_engine_top: FAILED **");
      $finish;
   end
endmodule

// File: sim.f
src/mpfe_pkg.sv
src/mpfe_front.sv
src/mpfe_back.sv
src/mono_page_framebuffer_engine_top.sv
verif/tb.sv
